FILE: rtl/core/hid_keyboard_report_to_xt_scancodes_defines.svh
// ----------------------------------------------------------------------------
// HID keyboard to XT scancode translator: assertion macros
// Shared property wrappers for the checker on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_TO_XT_SCANCODES_DEFINES_SVH
`define HID_KEYBOARD_REPORT_TO_XT_SCANCODES_DEFINES_SVH

// Property checked on every clock edge, muted while reset is held.
`define HKXT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define HKXT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/hkxt_pkg.sv
// ----------------------------------------------------------------------------
// HID keyboard to XT scancode translator: package
// Types, scancode constants and the usage-to-set-1 lookup table.
// ----------------------------------------------------------------------------
package hkxt_pkg;

    localparam int KEY_SLOTS_DEFAULT     = 4;
    localparam int TABLE_ENTRIES_DEFAULT = 100;
    localparam int IN_SLOTS              = 4;
    localparam int SLOT_MAX              = 6;
    localparam int MOD_GROUPS            = 3;
    localparam int ONES_W                = $clog2(SLOT_MAX + 1);

    typedef logic [7:0] usage_t;
    typedef logic [7:0] scancode_t;

    localparam scancode_t BREAK_BIT = 8'h80;

    // ctrl, shift, alt: left/right bit pair, make code, break code
    localparam logic [7:0] MOD_GROUP [MOD_GROUPS] = '{8'h11, 8'h22, 8'h44};
    localparam scancode_t  MOD_MAKE  [MOD_GROUPS] = '{8'h1D, 8'h2A, 8'h38};
    localparam scancode_t  MOD_BREAK [MOD_GROUPS] = '{8'h9D, 8'hAA, 8'hB8};

    typedef struct packed {
        logic      vld;
        scancode_t code;
    } mod_code_t;

    typedef struct packed {
        logic      make_vld;
        scancode_t make_code;
        logic      break_vld;
        scancode_t break_code;
    } lane_out_t;

    function automatic scancode_t usage_to_xt(input usage_t u);
        scancode_t r;
        unique case (u)
            8'd4:  r = 8'h1E;  8'd5:  r = 8'h30;  8'd6:  r = 8'h2E;  8'd7:  r = 8'h20;
            8'd8:  r = 8'h12;  8'd9:  r = 8'h21;  8'd10: r = 8'h22;  8'd11: r = 8'h23;
            8'd12: r = 8'h17;  8'd13: r = 8'h24;  8'd14: r = 8'h25;  8'd15: r = 8'h26;
            8'd16: r = 8'h32;  8'd17: r = 8'h31;  8'd18: r = 8'h18;  8'd19: r = 8'h19;
            8'd20: r = 8'h10;  8'd21: r = 8'h13;  8'd22: r = 8'h1F;  8'd23: r = 8'h14;
            8'd24: r = 8'h16;  8'd25: r = 8'h2F;  8'd26: r = 8'h11;  8'd27: r = 8'h2D;
            8'd28: r = 8'h15;  8'd29: r = 8'h2C;  8'd30: r = 8'h02;  8'd31: r = 8'h03;
            8'd32: r = 8'h04;  8'd33: r = 8'h05;  8'd34: r = 8'h06;  8'd35: r = 8'h07;
            8'd36: r = 8'h08;  8'd37: r = 8'h09;  8'd38: r = 8'h0A;  8'd39: r = 8'h0B;
            8'd40: r = 8'h1C;  8'd41: r = 8'h01;  8'd42: r = 8'h0E;  8'd43: r = 8'h0F;
            8'd44: r = 8'h39;  8'd45: r = 8'h0C;  8'd46: r = 8'h0D;  8'd47: r = 8'h1A;
            8'd48: r = 8'h1B;  8'd49: r = 8'h2B;  8'd51: r = 8'h27;
            8'd52: r = 8'h28;  8'd53: r = 8'h29;  8'd54: r = 8'h33;  8'd55: r = 8'h34;
            8'd56: r = 8'h35;  8'd57: r = 8'h3A;  8'd58: r = 8'h3B;  8'd59: r = 8'h3C;
            8'd60: r = 8'h3D;  8'd61: r = 8'h3E;  8'd62: r = 8'h3F;  8'd63: r = 8'h40;
            8'd64: r = 8'h41;  8'd65: r = 8'h42;  8'd66: r = 8'h43;  8'd67: r = 8'h44;
            8'd68: r = 8'h57;  8'd69: r = 8'h58;  8'd71: r = 8'h46;
            8'd73: r = 8'h52;  8'd74: r = 8'h47;  8'd75: r = 8'h49;
            8'd76: r = 8'h53;  8'd77: r = 8'h4F;  8'd78: r = 8'h51;  8'd79: r = 8'h4D;
            8'd80: r = 8'h4B;  8'd81: r = 8'h50;  8'd82: r = 8'h48;  8'd83: r = 8'h45;
            8'd84: r = 8'h35;  8'd85: r = 8'h37;  8'd86: r = 8'h4A;  8'd87: r = 8'h4E;
            8'd88: r = 8'h1C;  8'd89: r = 8'h4F;  8'd90: r = 8'h50;  8'd91: r = 8'h51;
            8'd92: r = 8'h4B;  8'd93: r = 8'h4C;  8'd94: r = 8'h4D;  8'd95: r = 8'h47;
            8'd96: r = 8'h48;  8'd97: r = 8'h49;  8'd98: r = 8'h52;  8'd99: r = 8'h53;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Usages at or past the table size have no code.
    function automatic scancode_t xt_lookup(input usage_t u, input int entries);
        scancode_t r;
        r = 8'h00;
        if ({1'b0, u} < 9'(entries)) begin
            r = usage_to_xt(u);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/hkxt_front.sv
// ----------------------------------------------------------------------------
// HID keyboard to XT scancode translator: input stage
// Masks slots by report length, sorts them, tracks modifier and key state.
// ----------------------------------------------------------------------------
module hkxt_front #(
    parameter int SLOT_COUNT = hkxt_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_modifiers,
    input  logic [7:0]           s_key_slot_a,
    input  logic [7:0]           s_key_slot_b,
    input  logic [7:0]           s_key_slot_c,
    input  logic [7:0]           s_key_slot_d,
    input  logic [6:0]           s_report_length,
    input  logic                 take,
    output logic                 out_valid,
    output hkxt_pkg::mod_code_t  mod_codes [hkxt_pkg::MOD_GROUPS],
    output hkxt_pkg::usage_t     cur_keys  [SLOT_COUNT],
    output hkxt_pkg::usage_t     prev_keys [SLOT_COUNT],
    output logic                 rollover
);

    logic                       valid_reg, valid_next;
    logic [7:0]                 prev_mods_reg;
    hkxt_pkg::usage_t           prev_keys_reg [SLOT_COUNT];
    hkxt_pkg::usage_t           cur_reg       [SLOT_COUNT];
    hkxt_pkg::usage_t           snap_reg      [SLOT_COUNT];
    hkxt_pkg::mod_code_t        mod_reg       [hkxt_pkg::MOD_GROUPS];
    logic                       rollover_reg;

    logic [8*hkxt_pkg::IN_SLOTS-1:0] in_bus;
    hkxt_pkg::usage_t           net [SLOT_COUNT+1][SLOT_COUNT];
    logic [hkxt_pkg::ONES_W-1:0] ones;
    logic                       over;
    hkxt_pkg::mod_code_t        mod_new [hkxt_pkg::MOD_GROUPS];
    logic                       accept;

    assign s_ready = !valid_reg || take;
    assign accept  = s_valid && s_ready;
    assign in_bus  = {s_key_slot_d, s_key_slot_c, s_key_slot_b, s_key_slot_a};

    // Slot masking, rollover count and odd-even transposition sort.
    always_comb begin
        ones = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            net[0][i] = '0;
            if (i < hkxt_pkg::IN_SLOTS && s_report_length > 7'(i + 2)) begin
                net[0][i] = in_bus[(i % hkxt_pkg::IN_SLOTS)*8 +: 8];
            end
            if (net[0][i] == 8'd1) begin
                ones = ones + hkxt_pkg::ONES_W'(1);
            end
        end
        for (int k = 0; k < SLOT_COUNT; k++) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                net[k+1][i] = net[k][i];
            end
            for (int i = k % 2; i + 1 < SLOT_COUNT; i += 2) begin
                if (net[k][i] > net[k][i+1]) begin
                    net[k+1][i]   = net[k][i+1];
                    net[k+1][i+1] = net[k][i];
                end
            end
        end
        over = ones > hkxt_pkg::ONES_W'(2);
    end

    always_comb begin
        for (int g = 0; g < hkxt_pkg::MOD_GROUPS; g++) begin
            mod_new[g].vld  = |((prev_mods_reg ^ s_modifiers) & hkxt_pkg::MOD_GROUP[g]);
            mod_new[g].code = |(s_modifiers & hkxt_pkg::MOD_GROUP[g]) ?
                              hkxt_pkg::MOD_MAKE[g] : hkxt_pkg::MOD_BREAK[g];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            prev_mods_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                prev_keys_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                prev_mods_reg <= s_modifiers;
                if (!over) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        prev_keys_reg[i] <= net[SLOT_COUNT][i];
                    end
                end
            end
        end
    end

    // Register the new and old key sets, rollover and modifier codes.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rollover_reg <= over;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                cur_reg[i]  <= net[SLOT_COUNT][i];
                snap_reg[i] <= prev_keys_reg[i];
            end
            for (int g = 0; g < hkxt_pkg::MOD_GROUPS; g++) begin
                mod_reg[g] <= mod_new[g];
            end
        end
    end

    assign out_valid = valid_reg;
    assign mod_codes = mod_reg;
    assign cur_keys  = cur_reg;
    assign prev_keys = snap_reg;
    assign rollover  = rollover_reg;

endmodule

FILE: rtl/core/hkxt_lane.sv
// ----------------------------------------------------------------------------
// HID keyboard to XT scancode translator: key lane
// One slot: make code if newly pressed, break code if released.
// ----------------------------------------------------------------------------
module hkxt_lane #(
    parameter int SLOT_COUNT    = hkxt_pkg::KEY_SLOTS_DEFAULT,
    parameter int TABLE_ENTRIES = hkxt_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int LANE          = 0
) (
    input  hkxt_pkg::usage_t    cur_keys  [SLOT_COUNT],
    input  hkxt_pkg::usage_t    prev_keys [SLOT_COUNT],
    input  logic                rollover,
    output hkxt_pkg::lane_out_t result
);

    hkxt_pkg::usage_t    cur_u, prev_u;
    hkxt_pkg::scancode_t make_c, brk_c;
    logic                cur_held, prev_held;

    assign cur_u  = cur_keys[LANE];
    assign prev_u = prev_keys[LANE];
    assign make_c = hkxt_pkg::xt_lookup(cur_u, TABLE_ENTRIES);
    assign brk_c  = hkxt_pkg::xt_lookup(prev_u, TABLE_ENTRIES);

    always_comb begin
        cur_held  = 1'b0;
        prev_held = 1'b0;
        for (int j = 0; j < SLOT_COUNT; j++) begin
            cur_held  = cur_held  || (prev_keys[j] == cur_u);
            prev_held = prev_held || (cur_keys[j] == prev_u);
        end
    end

    // Drop everything on rollover, and drop empty slots, held keys and unmapped usages.
    assign result.make_vld   = !rollover && (cur_u != '0) && !cur_held && (make_c != '0);
    assign result.make_code  = make_c;
    assign result.break_vld  = !rollover && (prev_u != '0) && !prev_held && (brk_c != '0);
    assign result.break_code = brk_c | hkxt_pkg::BREAK_BIT;

endmodule

FILE: rtl/core/hkxt_merge.sv
// ----------------------------------------------------------------------------
// HID keyboard to XT scancode translator: merge and output stage
// Collects modifier and lane codes, sends them one per cycle in order while m_ready is high.
// ----------------------------------------------------------------------------
module hkxt_merge #(
    parameter int SLOT_COUNT = hkxt_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  hkxt_pkg::mod_code_t  mod_codes [hkxt_pkg::MOD_GROUPS],
    input  hkxt_pkg::lane_out_t  lanes     [SLOT_COUNT],
    output logic                 buf_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_scancode,
    output logic                 m_last
);

    localparam int NUM = hkxt_pkg::MOD_GROUPS + 2*SLOT_COUNT;
    localparam int MK0 = hkxt_pkg::MOD_GROUPS;
    localparam int BK0 = hkxt_pkg::MOD_GROUPS + SLOT_COUNT;

    logic [NUM-1:0]      mask_reg, mask_next;
    hkxt_pkg::scancode_t codes_reg [NUM];
    logic [NUM-1:0]      new_mask;
    hkxt_pkg::scancode_t new_codes [NUM];
    logic [NUM-1:0]      low, rest;

    // Order: ctrl, shift, alt, makes by slot, breaks by slot.
    always_comb begin
        for (int g = 0; g < hkxt_pkg::MOD_GROUPS; g++) begin
            new_mask[g]  = mod_codes[g].vld;
            new_codes[g] = mod_codes[g].code;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            new_mask[MK0+i]  = lanes[i].make_vld;
            new_codes[MK0+i] = lanes[i].make_code;
            new_mask[BK0+i]  = lanes[i].break_vld;
            new_codes[BK0+i] = lanes[i].break_code;
        end
    end

    assign low  = mask_reg & (~mask_reg + NUM'(1));
    assign rest = mask_reg & (mask_reg - NUM'(1));

    always_comb begin
        m_scancode = '0;
        for (int i = 0; i < NUM; i++) begin
            m_scancode = m_scancode | (low[i] ? codes_reg[i] : '0);
        end
    end

    assign m_valid  = |mask_reg;
    assign m_last   = rest == '0;
    assign buf_free = mask_reg == '0;

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = new_mask;
        end else if (m_valid && m_ready) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            codes_reg <= new_codes;
        end
    end

endmodule

FILE: rtl/core/hid_keyboard_report_to_xt_scancodes.sv
// ----------------------------------------------------------------------------
// HID boot-keyboard report to XT set-1 scancode translator
// Turns each report into modifier, make and break scancodes, one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  s_      | in        | s_valid / s_ready  | modifiers, key slots a..d, length
//  m_      | out       | m_valid / m_ready  | scancode, last
//
//  A report yields k scancodes, k up to 3 + 2*SLOT_COUNT (11 at defaults). The output
//  buffer sends one per cycle while m_ready is high and reloads in the cycle after it
//  empties; the single output port limits how fast reports pass. A taken report is
//  registered in the input stage, then loaded into the output buffer. Reset clears
//  modifier and key state at once; there is no clearing pass. With m_ready low the
//  buffer holds and one further report waits in the input stage.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_xt_scancodes #(
    parameter int KEY_SLOTS     = hkxt_pkg::KEY_SLOTS_DEFAULT,
    parameter int TABLE_ENTRIES = hkxt_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_modifiers,
    input  logic [7:0] s_key_slot_a,
    input  logic [7:0] s_key_slot_b,
    input  logic [7:0] s_key_slot_c,
    input  logic [7:0] s_key_slot_d,
    input  logic [6:0] s_report_length,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_scancode,
    output logic       m_last
);

    // Clamp the slot count to what a boot report can carry.
    localparam int SLOT_COUNT = (KEY_SLOTS < 1) ? 1 :
                                ((KEY_SLOTS > hkxt_pkg::SLOT_MAX) ? hkxt_pkg::SLOT_MAX
                                                                  : KEY_SLOTS);

    logic                 front_valid;
    logic                 buf_free;
    logic                 load;
    logic                 rollover;
    hkxt_pkg::mod_code_t  mod_codes [hkxt_pkg::MOD_GROUPS];
    hkxt_pkg::usage_t     cur_keys  [SLOT_COUNT];
    hkxt_pkg::usage_t     prev_keys [SLOT_COUNT];
    hkxt_pkg::lane_out_t  lanes     [SLOT_COUNT];

    // Advance the input stage into the buffer only once the buffer is empty.
    assign load = front_valid && buf_free;

    // Sort the slots and update key state as each report is taken.
    hkxt_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_modifiers     (s_modifiers),
        .s_key_slot_a    (s_key_slot_a),
        .s_key_slot_b    (s_key_slot_b),
        .s_key_slot_c    (s_key_slot_c),
        .s_key_slot_d    (s_key_slot_d),
        .s_report_length (s_report_length),
        .take            (load),
        .out_valid       (front_valid),
        .mod_codes       (mod_codes),
        .cur_keys        (cur_keys),
        .prev_keys       (prev_keys),
        .rollover        (rollover)
    );

    // One lane per slot finds that slot's make and break codes.
    for (genvar l = 0; l < SLOT_COUNT; l++) begin : g_lane
        hkxt_lane #(
            .SLOT_COUNT    (SLOT_COUNT),
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .LANE          (l)
        ) u_lane (
            .cur_keys  (cur_keys),
            .prev_keys (prev_keys),
            .rollover  (rollover),
            .result    (lanes[l])
        );
    end

    // Merge the lane results and drain them in report order.
    hkxt_merge #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .mod_codes  (mod_codes),
        .lanes      (lanes),
        .buf_free   (buf_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_scancode (m_scancode),
        .m_last     (m_last)
    );

endmodule

FILE: rtl/core/hkxt_checker.sv
// ----------------------------------------------------------------------------
// HID keyboard to XT scancode translator: port checker
// Watches the top-level ports for burst and handshake behavior.
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_to_xt_scancodes_defines.svh"

module hkxt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_scancode,
    input logic       m_last
);

    // Nothing is offered right after reset.
    `HKXT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // With no result pending the input side must be open.
    `HKXT_ASSERT_ALWAYS(a_idle_ready, aclk, !m_valid |-> s_ready, "input stalled while idle")

    // A report's scancodes leave as one unbroken burst.
    `HKXT_ASSERT(a_burst_gapless, aclk, aresetn, m_valid && m_ready && !m_last |=> m_valid,
                 "gap inside a scancode burst")

    // A stalled item holds.
    `HKXT_ASSERT(a_hold_stall, aclk, aresetn,
                 m_valid && !m_ready |=> m_valid && $stable(m_scancode) && $stable(m_last),
                 "stalled result changed")

endmodule

bind hid_keyboard_report_to_xt_scancodes hkxt_checker u_hkxt_checker (.*);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// HID keyboard report to XT scancode translator: self-checking testbench
// Drives boot-keyboard reports through the valid/ready input channel and
// checks every scancode on the output channel against a cycle-free predictor
// kept in step with the block. A directed table with the edge cases comes
// first, then random typing sequences mixed with rollover reports and noise.
// ----------------------------------------------------------------------------
module testbench;

    // Modifier groups: left/right bit pair, make code, break code.
    localparam bit [7:0] CTRL_BITS   = 8'h11;
    localparam bit [7:0] SHIFT_BITS  = 8'h22;
    localparam bit [7:0] ALT_BITS    = 8'h44;
    localparam bit [7:0] CTRL_MAKE   = 8'h1D;
    localparam bit [7:0] CTRL_BREAK  = 8'h9D;
    localparam bit [7:0] SHIFT_MAKE  = 8'h2A;
    localparam bit [7:0] SHIFT_BREAK = 8'hAA;
    localparam bit [7:0] ALT_MAKE    = 8'h38;
    localparam bit [7:0] ALT_BREAK   = 8'hB8;
    localparam bit [7:0] BREAK_FLAG  = 8'h80;
    localparam bit [7:0] ERR_ROLLOVER_USAGE = 8'h01;

    localparam bit [0:2][7:0] GROUP_BITS  = {CTRL_BITS, SHIFT_BITS, ALT_BITS};
    localparam bit [0:2][7:0] GROUP_MAKE  = {CTRL_MAKE, SHIFT_MAKE, ALT_MAKE};
    localparam bit [0:2][7:0] GROUP_BREAK = {CTRL_BREAK, SHIFT_BREAK, ALT_BREAK};

    localparam int USAGE_LIMIT    = 100;
    localparam int MAX_RUN        = 11;
    localparam int DIRECTED_ROWS  = 22;
    localparam int RANDOM_REPORTS = 350;
    localparam int QUIET_FROM     = 310;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 24;
    localparam int REPORT_MAX     = 10;

    // USB usage to set-1 make code; zero means no key.
    localparam bit [0:99][7:0] XT_SET1 = {
        8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
        8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
        8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
        8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
        8'h1B, 8'h2B, 8'h00, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
        8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00, 8'h46,
        8'h00, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51, 8'h4D,
        8'h4B, 8'h50, 8'h48, 8'h45, 8'h35, 8'h37, 8'h4A, 8'h4E,
        8'h1C, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47,
        8'h48, 8'h49, 8'h52, 8'h53
    };

    typedef struct packed {
        bit [7:0] mods;
        bit [7:0] slot_a;
        bit [7:0] slot_b;
        bit [7:0] slot_c;
        bit [7:0] slot_d;
        bit [6:0] length;
    } hid_report_t;

    typedef struct packed {
        bit [7:0] scancode;
        bit       last;
    } xt_byte_t;

    // A directed row either carries its scancodes typed in (literal set) or
    // leaves them to the predictor.
    typedef struct packed {
        hid_report_t rpt;
        bit          literal;
        bit [1:0]    n_lit;
        bit [7:0]    lit0;
        bit [7:0]    lit1;
        bit [7:0]    lit2;
    } stim_row_t;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_modifiers     = 8'h00;
    logic [7:0] s_key_slot_a    = 8'h00;
    logic [7:0] s_key_slot_b    = 8'h00;
    logic [7:0] s_key_slot_c    = 8'h00;
    logic [7:0] s_key_slot_d    = 8'h00;
    logic [6:0] s_report_length = 7'd0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [7:0] m_scancode;
    logic       m_last;

    // Predictor state: a shadow of the block's modifier byte and key set.
    bit [7:0] last_mods;
    bit [7:0] held_keys [4];
    bit [7:0] run_codes [MAX_RUN];
    int       run_len;

    xt_byte_t scancodes_due [$];

    // Stimulus shaping and bookkeeping.
    bit       tx_idle_on = 1'b1;
    bit       rx_idle_on = 1'b1;
    int       rx_stall_left = 0;
    int       mismatch_count = 0;
    int       codes_checked = 0;
    int       reports_sent = 0;
    int       rollover_reports = 0;
    int       longest_run = 0;
    bit [7:0] typing_keys [4];
    bit [7:0] typing_mods;

    stim_row_t directed [DIRECTED_ROWS] = '{
        // Ctrl plus A from reset.
        '{'{8'h01, 8'd4,   8'd0,   8'd0,   8'd0,   7'd8},  1'b1, 2'd2,
          CTRL_MAKE, 8'h1E, 8'h00},
        // Right ctrl joins left ctrl: the group bits change, so make again.
        '{'{8'h11, 8'd4,   8'd0,   8'd0,   8'd0,   7'd8},  1'b1, 2'd1,
          CTRL_MAKE, 8'h00, 8'h00},
        '{'{8'h00, 8'd0,   8'd0,   8'd0,   8'd0,   7'd8},  1'b1, 2'd2,
          CTRL_BREAK, 8'h9E, 8'h00},
        // All modifiers on, then off; a length of two hides every slot.
        '{'{8'hFF, 8'd7,   8'd8,   8'd9,   8'd10,  7'd2},  1'b1, 2'd3,
          CTRL_MAKE, SHIFT_MAKE, ALT_MAKE},
        '{'{8'h00, 8'd0,   8'd0,   8'd0,   8'd0,   7'd2},  1'b1, 2'd3,
          CTRL_BREAK, SHIFT_BREAK, ALT_BREAK},
        // Rollover: three error usages, modifier codes only, keys kept.
        '{'{8'h02, ERR_ROLLOVER_USAGE, ERR_ROLLOVER_USAGE, ERR_ROLLOVER_USAGE,
            8'd4, 7'd8}, 1'b1, 2'd1, SHIFT_MAKE, 8'h00, 8'h00},
        // Two error usages are below the rollover threshold.
        '{'{8'h02, ERR_ROLLOVER_USAGE, ERR_ROLLOVER_USAGE, 8'd4, 8'd0,
            7'd8}, 1'b1, 2'd1, 8'h1E, 8'h00, 8'h00},
        // Usages past the table: held, but silent.
        '{'{8'h02, 8'd100, 8'd255, 8'd4,   8'd0,   7'd8},  1'b1, 2'd0,
          8'h00, 8'h00, 8'h00},
        // Same usage in two slots.
        '{'{8'h02, 8'd5,   8'd5,   8'd0,   8'd0,   7'd8},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        // Zero length: every slot reads empty; right shift only.
        '{'{8'h20, 8'd6,   8'd7,   8'd8,   8'd9,   7'd0},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        '{'{8'h40, 8'd68,  8'd69,  8'd0,   8'd0,   7'd64}, 1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        // Lengths that expose one, three and four slots.
        '{'{8'h40, 8'd8,   8'd9,   8'd10,  8'd11,  7'd3},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        '{'{8'h40, 8'd8,   8'd9,   8'd10,  8'd11,  7'd5},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        '{'{8'h40, 8'd11,  8'd10,  8'd9,   8'd8,   7'd6},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        // Unmapped usages inside the table.
        '{'{8'h00, 8'd50,  8'd70,  8'd72,  8'd0,   7'd8},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        // GUI bits only: no group changes, unmapped releases are silent.
        '{'{8'h88, 8'd0,   8'd0,   8'd0,   8'd0,   7'd8},  1'b1, 2'd0,
          8'h00, 8'h00, 8'h00},
        '{'{8'h00, 8'd4,   8'd5,   8'd6,   8'd7,   7'd8},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        // Longest run: three groups, four makes, four breaks.
        '{'{8'h77, 8'd99,  8'd98,  8'd97,  8'd96,  7'd8},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        '{'{8'h00, 8'd255, 8'd255, 8'd255, 8'd255, 7'd8},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        '{'{8'hAA, 8'h80,  8'h7F,  8'h55,  8'hAA,  7'd64}, 1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        '{'{8'h00, 8'd0,   8'd0,   8'd0,   8'd0,   7'd0},  1'b0, 2'd0,
          8'h00, 8'h00, 8'h00},
        '{'{8'h55, ERR_ROLLOVER_USAGE, ERR_ROLLOVER_USAGE, ERR_ROLLOVER_USAGE,
            ERR_ROLLOVER_USAGE, 7'd8}, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
    };

    hid_keyboard_report_to_xt_scancodes dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_modifiers     (s_modifiers),
        .s_key_slot_a    (s_key_slot_a),
        .s_key_slot_b    (s_key_slot_b),
        .s_key_slot_c    (s_key_slot_c),
        .s_key_slot_d    (s_key_slot_d),
        .s_report_length (s_report_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scancode      (m_scancode),
        .m_last          (m_last)
    );

    always #2 aclk = ~aclk;

    function automatic bit [7:0] set1_code(input bit [7:0] usage);
        return (usage < USAGE_LIMIT) ? XT_SET1[usage] : 8'h00;
    endfunction

    // Work out the scancodes one report causes and advance the shadow state.
    // Leaves them in run_codes[0 .. run_len-1].
    task automatic translate_report(input hid_report_t r);
        bit [7:0] cur [4];
        bit [7:0] tmp;
        bit [7:0] code;
        bit       swapped;
        bit       found;
        int       ones;
        run_len = 0;
        ones = 0;
        for (int g = 0; g < 3; g++) begin
            if (((last_mods ^ r.mods) & GROUP_BITS[g]) != 0) begin
                run_codes[run_len] = ((r.mods & GROUP_BITS[g]) != 0) ?
                                     GROUP_MAKE[g] : GROUP_BREAK[g];
                run_len++;
            end
        end
        last_mods = r.mods;

        // Slots past the report length read as empty.
        cur[0] = (r.length > 7'd2) ? r.slot_a : 8'h00;
        cur[1] = (r.length > 7'd3) ? r.slot_b : 8'h00;
        cur[2] = (r.length > 7'd4) ? r.slot_c : 8'h00;
        cur[3] = (r.length > 7'd5) ? r.slot_d : 8'h00;
        for (int i = 0; i < 4; i++) begin
            if (cur[i] == ERR_ROLLOVER_USAGE) ones++;
        end

        if (ones > 2) begin
            // Rollover: keep the key set, send modifier codes only.
            rollover_reports++;
        end else begin
            do begin
                swapped = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    if (cur[i] > cur[i + 1]) begin
                        tmp = cur[i];
                        cur[i] = cur[i + 1];
                        cur[i + 1] = tmp;
                        swapped = 1'b1;
                    end
                end
            end while (swapped);

            // Makes for new keys in ascending usage order.
            for (int i = 0; i < 4; i++) begin
                found = 1'b0;
                for (int j = 0; j < 4; j++) begin
                    if (held_keys[j] == cur[i]) found = 1'b1;
                end
                code = set1_code(cur[i]);
                if (cur[i] != 8'h00 && !found && code != 8'h00) begin
                    run_codes[run_len] = code;
                    run_len++;
                end
            end

            // Breaks for released keys in stored order.
            for (int i = 0; i < 4; i++) begin
                found = 1'b0;
                for (int j = 0; j < 4; j++) begin
                    if (cur[j] == held_keys[i]) found = 1'b1;
                end
                code = set1_code(held_keys[i]);
                if (held_keys[i] != 8'h00 && !found && code != 8'h00) begin
                    run_codes[run_len] = code | BREAK_FLAG;
                    run_len++;
                end
            end
            held_keys = cur;
        end
    endtask

    // Offer one report and hold it until the block takes it. On entry the
    // caller sits just past a clock edge; on return the report was accepted
    // at the current edge. Optionally drain all expected results first.
    task automatic offer_report(input hid_report_t r, input bit drain_first);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
        if (drain_first || gap != 0) begin
            s_valid <= 1'b0;
            if (drain_first) begin
                do @(posedge aclk); while (scancodes_due.size() != 0);
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_modifiers     <= r.mods;
        s_key_slot_a    <= r.slot_a;
        s_key_slot_b    <= r.slot_b;
        s_key_slot_c    <= r.slot_c;
        s_key_slot_d    <= r.slot_d;
        s_report_length <= r.length;
        do @(posedge aclk); while (!s_ready);
        reports_sent++;
    endtask

    // Queue the predicted run; the final byte of a run carries last.
    task automatic queue_run();
        for (int k = 0; k < run_len; k++) begin
            scancodes_due.push_back('{scancode: run_codes[k], last: (k == run_len - 1)});
        end
        if (run_len > longest_run) longest_run = run_len;
    endtask

    // Build the next random report. Most are plausible typing: one key
    // pressed or released against a running key set, modifiers toggled now
    // and then. The rest are rollover reports and raw noise.
    function automatic hid_report_t next_random_report();
        hid_report_t r;
        int unsigned kind;
        int unsigned pick;
        int unsigned rot;
        bit [7:0]    usage;
        kind = $urandom_range(0, 19);
        if (kind <= 12) begin
            pick = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0:       usage = 8'($urandom_range(100, 255));
                1:       usage = typing_keys[$urandom_range(0, 3)];
                2, 3, 4: usage = 8'h00;
                default: usage = 8'($urandom_range(4, USAGE_LIMIT - 1));
            endcase
            typing_keys[pick] = usage;
            if ($urandom_range(0, 2) == 0) typing_mods ^= 8'(1 << $urandom_range(0, 7));
            rot = $urandom_range(0, 3);
            r.mods   = typing_mods;
            r.slot_a = typing_keys[rot];
            r.slot_b = typing_keys[(rot + 1) % 4];
            r.slot_c = typing_keys[(rot + 2) % 4];
            r.slot_d = typing_keys[(rot + 3) % 4];
            r.length = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 64)) : 7'd8;
        end else if (kind <= 15) begin
            r.mods   = typing_mods;
            r.slot_a = ERR_ROLLOVER_USAGE;
            r.slot_b = ERR_ROLLOVER_USAGE;
            r.slot_c = ERR_ROLLOVER_USAGE;
            r.slot_d = ERR_ROLLOVER_USAGE;
            case ($urandom_range(0, 3))
                0: r.slot_a = 8'($urandom);
                1: r.slot_b = 8'($urandom);
                2: r.slot_c = 8'($urandom);
                default: r.slot_d = 8'($urandom);
            endcase
            r.length = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64)) : 7'd8;
        end else begin
            r.mods   = 8'($urandom);
            r.slot_a = 8'($urandom);
            r.slot_b = 8'($urandom);
            r.slot_c = 8'($urandom);
            r.slot_d = 8'($urandom);
            r.length = 7'($urandom_range(0, 64));
        end
        return r;
    endfunction

    // Result side: stall in random bursts, never in the no-idle stretches or the quiet tail.
    always @(posedge aclk) begin
        if (!aresetn || !rx_idle_on) begin
            rx_stall_left <= 0;
            m_ready       <= 1'b1;
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_ready       <= (rx_stall_left == 1);
        end else if ($urandom_range(0, 7) == 0) begin
            rx_stall_left <= $urandom_range(1, 12);
            m_ready       <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every accepted scancode with the oldest expectation.
    always @(posedge aclk) begin
        xt_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            codes_checked++;
            if (scancodes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected scancode %02h last %0d", m_scancode, m_last);
            end else begin
                want = scancodes_due.pop_front();
                if (m_scancode !== want.scancode || m_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("scancode exp %02h got %02h, last exp %0d got %0d",
                                 want.scancode, m_scancode, want.last, m_last);
                end
            end
        end
    end

    // Stop a hung run.
    initial begin
        #2000000;
        $display("FAIL hid_keyboard_report_to_xt_scancodes");
        $finish;
    end

    initial begin
        hid_report_t rpt;
        int          waited;
        last_mods   = 8'h00;
        typing_mods = 8'h00;
        for (int i = 0; i < 4; i++) begin
            held_keys[i]   = 8'h00;
            typing_keys[i] = 8'h00;
        end

        // Hold reset, then release it once.
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: typed-in rows still advance the shadow state.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer_report(directed[i].rpt, 1'b0);
            translate_report(directed[i].rpt);
            if (directed[i].literal) begin
                run_len = directed[i].n_lit;
                run_codes[0] = directed[i].lit0;
                run_codes[1] = directed[i].lit1;
                run_codes[2] = directed[i].lit2;
            end
            queue_run();
        end

        // Random part: stretches without idling every fourth block, a full
        // drain twice, and a quiet tail at the end.
        for (int i = 0; i < RANDOM_REPORTS; i++) begin
            tx_idle_on = (i < QUIET_FROM) && ((i / 30) % 4 != 3);
            rx_idle_on = tx_idle_on;
            rpt = next_random_report();
            offer_report(rpt, (i == 60) || (i == 175));
            translate_report(rpt);
            queue_run();
        end
        s_valid <= 1'b0;

        // Drain what is still owed, then give the block time to misbehave.
        waited = 0;
        while (scancodes_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d reports (%0d rollover), %0d scancodes checked, longest run %0d",
                 reports_sent, rollover_reports, codes_checked, longest_run);
        $display("%0d mismatches, %0d scancodes never seen",
                 mismatch_count, scancodes_due.size());
        if (mismatch_count == 0 && scancodes_due.size() == 0) begin
            $display("PASS hid_keyboard_report_to_xt_scancodes");
        end else begin
            $display("FAIL hid_keyboard_report_to_xt_scancodes");
        end
        $finish;
    end

endmodule
